[rtl/cs_pkg.sv]
// ----------------------------------------------------------------------------
// cs_pkg
// Shared constants and types for the comment stripper: the character codes
// it matches and the queue entry that carries a classified input beat.
// ----------------------------------------------------------------------------
package cs_pkg;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One classified input beat: one or two results.
    typedef struct packed {
        logic       two;    // second result present
        logic [7:0] b0;     // first result byte
        logic       p0;     // first result carries a byte
        logic [7:0] b1;     // second result byte (always present)
        logic       fin;    // beat was the last of the text
    } t_entry;

endpackage

[rtl/cs_front.sv]
// ----------------------------------------------------------------------------
// cs_front
// Front end: tracks the scan mode and classifies each accepted byte that
// yields results into a queue entry holding the one or two results it causes.
// ----------------------------------------------------------------------------
module cs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    input  logic             i_final_byte,
    output logic             o_ent_valid,
    output cs_pkg::t_entry   o_ent
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_BLOCK  = 3'd3;
    localparam logic [2:0] MODE_STAR   = 3'd4;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic       hv0;
    logic       hv1;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       p0;
    logic       norm;

    always_comb begin
        n_mode = r_mode;
        hv0    = 1'b0;
        hv1    = 1'b0;
        b0     = i_in_byte;
        b1     = i_in_byte;
        p0     = 1'b1;
        norm   = 1'b0;

        unique case (r_mode)
            MODE_SLASH: begin
                if (i_in_byte == cs_pkg::CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else if (i_in_byte == cs_pkg::CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else begin
                    hv0    = 1'b1;
                    b0     = cs_pkg::CH_SLASH;
                    n_mode = MODE_NORMAL;
                    norm   = 1'b1;
                end
            end
            MODE_LINE: begin
                if (i_in_byte == cs_pkg::CH_NL) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (i_in_byte == cs_pkg::CH_STAR) begin
                    n_mode = MODE_STAR;
                end
            end
            MODE_STAR: begin
                if (i_in_byte == cs_pkg::CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                end else if (i_in_byte != cs_pkg::CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
                norm   = 1'b1;
            end
        endcase

        if (norm) begin
            if (i_in_byte == cs_pkg::CH_SLASH) begin
                n_mode = MODE_SLASH;
            end else if (i_in_byte == cs_pkg::CH_HASH) begin
                n_mode = MODE_LINE;
            end else if (hv0) begin
                hv1 = 1'b1;
                b1  = i_in_byte;
            end else begin
                hv0 = 1'b1;
                b0  = i_in_byte;
            end
        end

        if (i_final_byte) begin
            if (n_mode == MODE_SLASH) begin
                if (hv0) begin
                    hv1 = 1'b1;
                    b1  = cs_pkg::CH_SLASH;
                end else begin
                    hv0 = 1'b1;
                    b0  = cs_pkg::CH_SLASH;
                end
            end
            if (!hv0) begin
                hv0 = 1'b1;
                b0  = 8'h00;
                p0  = 1'b0;
            end
            n_mode = MODE_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

    assign o_ent_valid = i_accept && hv0;
    assign o_ent.two   = hv1;
    assign o_ent.b0    = b0;
    assign o_ent.p0    = p0;
    assign o_ent.b1    = b1;
    assign o_ent.fin   = i_final_byte;

endmodule

[rtl/cs_queue.sv]
// ----------------------------------------------------------------------------
// cs_queue
// Short queue of classified entries between front and back end.
// ----------------------------------------------------------------------------
module cs_queue #(
    parameter int P_AW = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cs_pkg::t_entry   i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output cs_pkg::t_entry   o_data
);

    localparam int         DEPTH   = 1 << P_AW;
    localparam logic [P_AW:0] DEPTH_C = (P_AW + 1)'(DEPTH);

    cs_pkg::t_entry  r_mem [DEPTH];
    logic [P_AW-1:0] r_wr;
    logic [P_AW-1:0] r_rd;
    logic [P_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/cs_back.sv]
// ----------------------------------------------------------------------------
// cs_back
// Back end: takes entries from the queue and presents their results one
// beat at a time from an output register.
// ----------------------------------------------------------------------------
module cs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  cs_pkg::t_entry   i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_present,
    output logic             o_end_of_text,
    output logic             o_run_end
);

    cs_pkg::t_entry r_ent;
    logic           r_valid;
    logic           r_phase;
    logic           adv;
    logic           done_cur;
    logic           take;
    logic           last;

    assign adv      = i_pop && r_valid;
    assign last     = r_phase || !r_ent.two;
    assign done_cur = adv && last;
    assign take     = !r_valid || done_cur;
    assign o_q_pop  = take && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (adv && !last) begin
            r_phase <= 1'b1;
        end else if (take) begin
            r_valid <= !i_q_empty;
            r_phase <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_data;
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_phase ? r_ent.b1 : r_ent.b0;
    assign o_byte_present = r_phase ? 1'b1 : r_ent.p0;
    assign o_run_end      = last;
    assign o_end_of_text  = last && r_ent.fin;

endmodule

[rtl/comment_stripper_core.sv]
// ----------------------------------------------------------------------------
// comment_stripper_core
// Removes line and block comments from a byte stream; one byte per beat in,
// kept bytes and end markers out.
// ----------------------------------------------------------------------------
// An accepted byte's results go to the queue, then to the output register.
// Throughput: one byte per cycle in unless full, one result per cycle out
// while popped; a non-hash byte releasing a held slash yields two results.
// The entry queue holds 2**P_QUEUE_AW classified bytes.
// Reset (synchronous): mode returns to normal text, queue and output empty.
// ----------------------------------------------------------------------------
module comment_stripper_core #(
    parameter int P_QUEUE_AW = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_byte,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_end_of_text,
    output logic       o_run_end
);

    logic           accept;
    logic           ent_valid;
    cs_pkg::t_entry ent;
    logic           q_empty;
    logic           q_pop;
    cs_pkg::t_entry q_data;

    assign accept = push && !full;

    cs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_final_byte (i_final_byte),
        .o_ent_valid  (ent_valid),
        .o_ent        (ent)
    );

    cs_queue #(
        .P_AW (P_QUEUE_AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ent_valid),
        .i_data  (ent),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    cs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_data),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_end_of_text  (o_end_of_text),
        .o_run_end      (o_run_end)
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for comment_stripper_core. A fixed list of byte sequences covers
// the corner cases: held slash, both line comment openers, star runs in
// block comments, and the final byte outside a block. Random texts follow:
// mostly well-formed comments with random content, plus stray markers.
// A scan-mode model predicts every result beat, and each popped beat is
// checked against the oldest prediction. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum logic [2:0] {
        SM_NORMAL = 3'd0,
        SM_SLASH  = 3'd1,
        SM_LINE   = 3'd2,
        SM_BLOCK  = 3'd3,
        SM_STAR   = 3'd4
    } t_scan;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eot;
        logic       last;
    } t_kept;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         hold;
    } t_feed;

    localparam int N_RANDOM = 1850;
    localparam int N_CALM   = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       pop = 1'b0;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_byte_present;
    logic       o_end_of_text;
    logic       o_run_end;

    t_feed  text_q[$];
    t_kept  kept_q[$];
    t_scan  scan_mode = SM_NORMAL;
    t_kept  want;
    logic   took_in = 1'b0;
    int     gap_cnt = 0;
    int     stall_cnt = 0;
    int     fail_cnt = 0;

    comment_stripper_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_final_byte   (i_final_byte),
        .pop            (pop),
        .empty          (empty),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_end_of_text  (o_end_of_text),
        .o_run_end      (o_run_end)
    );

    always #5 i_clk = ~i_clk;

    // Mode update for one byte; queues the result beats it produces.
    task automatic strip_byte(input logic [7:0] b, input logic fin);
        t_kept res[2];
        int    n;
        bit    plain;
        n = 0;
        plain = 1'b0;
        case (scan_mode)
            SM_SLASH: begin
                if (b == cs_pkg::CH_SLASH) begin
                    scan_mode = SM_LINE;
                end else if (b == cs_pkg::CH_STAR) begin
                    scan_mode = SM_BLOCK;
                end else begin
                    res[n] = '{data: cs_pkg::CH_SLASH, present: 1'b1,
                               eot: 1'b0, last: 1'b0};
                    n++;
                    plain = 1'b1;
                end
            end
            SM_LINE: begin
                if (b == cs_pkg::CH_NL) scan_mode = SM_NORMAL;
            end
            SM_BLOCK: begin
                if (b == cs_pkg::CH_STAR) scan_mode = SM_STAR;
            end
            SM_STAR: begin
                if (b == cs_pkg::CH_SLASH) scan_mode = SM_NORMAL;
                else if (b != cs_pkg::CH_STAR) scan_mode = SM_BLOCK;
            end
            default: plain = 1'b1;
        endcase
        if (plain) begin
            if (b == cs_pkg::CH_SLASH) begin
                scan_mode = SM_SLASH;
            end else if (b == cs_pkg::CH_HASH) begin
                scan_mode = SM_LINE;
            end else begin
                res[n] = '{data: b, present: 1'b1, eot: 1'b0, last: 1'b0};
                n++;
                scan_mode = SM_NORMAL;
            end
        end
        if (fin) begin
            if (scan_mode == SM_SLASH) begin
                res[n] = '{data: cs_pkg::CH_SLASH, present: 1'b1,
                           eot: 1'b0, last: 1'b0};
                n++;
            end
            if (n == 0) begin
                res[n] = '{data: 8'h00, present: 1'b0, eot: 1'b0, last: 1'b0};
                n++;
            end
            res[n-1].eot = 1'b1;
            scan_mode = SM_NORMAL;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) kept_q.push_back(res[k]);
    endtask

    task automatic queue_item(input logic [7:0] b, input logic fin, input bit hold);
        t_feed f;
        f.data = b;
        f.fin = fin;
        f.hold = hold;
        text_q.push_back(f);
    endtask

    // One random text: mostly complete comments with random bodies, some noise.
    task automatic make_text(input bit hold_first);
        logic [7:0] txt[$];
        int         n_tok;
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
            case ($urandom_range(0, 7))
                0, 1: txt.push_back(8'($urandom_range(0, 255)));
                2: begin
                    txt.push_back(cs_pkg::CH_SLASH);
                    txt.push_back(cs_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 6)) txt.push_back(8'($urandom_range(0, 255)));
                    txt.push_back(cs_pkg::CH_NL);
                end
                3: begin
                    txt.push_back(cs_pkg::CH_HASH);
                    repeat ($urandom_range(0, 6)) txt.push_back(8'($urandom_range(0, 255)));
                    txt.push_back(cs_pkg::CH_NL);
                end
                4, 5: begin
                    txt.push_back(cs_pkg::CH_SLASH);
                    txt.push_back(cs_pkg::CH_STAR);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 2) == 0) txt.push_back(cs_pkg::CH_STAR);
                        else txt.push_back(8'($urandom_range(0, 255)));
                    end
                    repeat ($urandom_range(1, 3)) txt.push_back(cs_pkg::CH_STAR);
                    txt.push_back(cs_pkg::CH_SLASH);
                end
                6: begin
                    txt.push_back(cs_pkg::CH_SLASH);
                    txt.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: txt.push_back(cs_pkg::CH_NL);
                        1: txt.push_back(cs_pkg::CH_HASH);
                        2: txt.push_back(cs_pkg::CH_STAR);
                        default: txt.push_back(cs_pkg::CH_SLASH);
                    endcase
                end
            endcase
        end
        for (int k = 0; k < txt.size(); k++)
            queue_item(txt[k], k == txt.size() - 1, hold_first && k == 0);
    endtask

    // Input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!push || took_in)) begin
            if (gap_cnt != 0) begin
                gap_cnt <= gap_cnt - 1;
                push <= 1'b0;
            end else if (text_q.size() == 0) begin
                push <= 1'b0;
            end else if (text_q[0].hold && kept_q.size() != 0) begin
                push <= 1'b0;
            end else if (text_q.size() >= N_CALM && $urandom_range(0, 9) == 0) begin
                gap_cnt <= $urandom_range(0, 5);
                push <= 1'b0;
            end else begin
                push <= 1'b1;
                i_in_byte <= text_q[0].data;
                i_final_byte <= text_q[0].fin;
                text_q.pop_front();
            end
        end
    end

    // Output side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            pop <= 1'b0;
        end else if (text_q.size() >= N_CALM && $urandom_range(0, 7) == 0) begin
            stall_cnt <= $urandom_range(0, 5);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Monitor: predict on each input beat, check each result beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took_in <= push && !full;
            if (push && !full) strip_byte(i_in_byte, i_final_byte);
            if (pop && !empty) begin
                if (kept_q.size() == 0) begin
                    $error("unexpected result beat: out_byte %0h", o_out_byte);
                    fail_cnt++;
                end else begin
                    want = kept_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                        fail_cnt++;
                    end
                    if (o_byte_present !== want.present) begin
                        $error("byte_present: expected %0b, got %0b",
                               want.present, o_byte_present);
                        fail_cnt++;
                    end
                    if (o_end_of_text !== want.eot) begin
                        $error("end_of_text: expected %0b, got %0b",
                               want.eot, o_end_of_text);
                        fail_cnt++;
                    end
                    if (o_run_end !== want.last) begin
                        $error("run_end: expected %0b, got %0b", want.last, o_run_end);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        int n_text;
        // plain extremes, last one ends a text
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        // held slash released by a plain byte
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_item(8'h61, 1'b0, 1'b0);
        // slash-slash comment up to newline
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_item(8'h78, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_NL, 1'b0, 1'b0);
        // newline right after hash
        queue_item(cs_pkg::CH_HASH, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_NL, 1'b0, 1'b0);
        // block comment with star runs
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_STAR, 1'b0, 1'b0);
        queue_item(8'h71, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_STAR, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_STAR, 1'b0, 1'b0);
        queue_item(8'h7A, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_STAR, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        // held slash then hash opens a line comment
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_HASH, 1'b0, 1'b0);
        queue_item(8'h6B, 1'b0, 1'b0);
        queue_item(cs_pkg::CH_NL, 1'b0, 1'b0);
        // final byte: held slash, inside comment, slash plus byte
        queue_item(cs_pkg::CH_SLASH, 1'b1, 1'b0);
        queue_item(cs_pkg::CH_HASH, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b0);
        queue_item(cs_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);

        n_text = 0;
        while (text_q.size() < N_RANDOM + 27) begin
            make_text(n_text == 0 || n_text == 40 || n_text == 120);
            n_text++;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || push) @(posedge i_clk);
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
